// ===== rtl/sph_pkg.sv =====
package sph_pkg;

  // Default widths of the byte counters and of the poll timer.
  localparam int COUNT_BITS_DEF = 16;
  localparam int TIMER_BITS_DEF = 17;

  // Reset values of the timeout registers, in polls.
  localparam logic [15:0] REQ_TIMEOUT_RST  = 16'(1000 * 50);
  localparam logic [15:0] NREQ_TIMEOUT_RST = 16'(1000 * 25);

  // Configuration register indexes.
  localparam logic CFG_REQ_TIMEOUT  = 1'b0;
  localparam logic CFG_NREQ_TIMEOUT = 1'b1;

  // Item kinds.
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_START = 1'b1;

  // Transfer sequencer states.
  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_WREQ  = 2'd1,
    MODE_WNREQ = 2'd2
  } mode_t;

  // End-of-transfer status codes.
  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_BSY   = 3'd1,
    ST_NOREQ = 3'd2,
    ST_PHASE = 3'd3,
    ST_STUCK = 3'd4
  } status_t;

  // One input word, unpacked.
  typedef struct packed {
    logic        func;
    logic        direction;
    logic [2:0]  expected_phase;
    logic [15:0] byte_count;
    logic        bus_busy;
    logic        bus_req;
    logic [2:0]  bus_phase;
    logic [7:0]  bus_data;
    logic [7:0]  out_byte;
  } in_item_t;

  // One result word, unpacked.
  typedef struct packed {
    logic        ack_drive;
    logic        data_drive_enable;
    logic [7:0]  data_out;
    logic        out_byte_taken;
    logic        in_byte_valid;
    logic [7:0]  in_byte;
    logic        done_res;
    logic [2:0]  status;
    logic [15:0] transferred;
  } out_item_t;

endpackage

// ===== rtl/sph_core.sv =====
module sph_core import sph_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  in_item_t    item,
  input  logic [15:0] req_timeout,
  input  logic [15:0] nreq_timeout,
  output out_item_t   result
);

  localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  mode_t                 mode_r, mode_nxt;
  logic                  is_output_r, is_output_nxt;
  logic [2:0]            phase_wanted_r, phase_wanted_nxt;
  logic [COUNT_BITS-1:0] total_bytes_r, total_bytes_nxt;
  logic [COUNT_BITS-1:0] bytes_left_r, bytes_left_nxt;
  logic [TIMER_BITS-1:0] poll_counter_r, poll_counter_nxt;
  logic                  first_poll_r, first_poll_nxt;
  logic                  ack_level_r, ack_level_nxt;
  logic                  drive_level_r, drive_level_nxt;
  logic [7:0]            held_byte_r, held_byte_nxt;

  logic                  in_wreq, in_wnreq;
  logic [COUNT_BITS-1:0] start_count;
  logic [COUNT_BITS-1:0] left_dec;
  logic [TIMER_BITS-1:0] poll_bumped;
  logic [CMP_W-1:0]      poll_cmp;
  logic                  zero_start, bsy_fail, req_seen, phase_fail, take_byte;
  logic                  noreq_fail, released, ok_end, stuck_fail, finish;
  status_t               end_status;

  // Decisions for the current poll or start word.
  always_comb begin
    in_wreq     = (item.func == FUNC_TICK) && (mode_r == MODE_WREQ);
    in_wnreq    = (item.func == FUNC_TICK) && (mode_r == MODE_WNREQ);
    start_count = COUNT_BITS'(item.byte_count);
    left_dec    = bytes_left_r - COUNT_BITS'(1);
    poll_bumped = (poll_counter_r == '1) ? poll_counter_r
                                         : poll_counter_r + TIMER_BITS'(1);
    poll_cmp    = CMP_W'(poll_bumped);
    zero_start  = (item.func == FUNC_START) && (start_count == '0);
    bsy_fail    = in_wreq && first_poll_r && !item.bus_busy;
    req_seen    = in_wreq && !bsy_fail && item.bus_req;
    phase_fail  = req_seen && (item.bus_phase != phase_wanted_r);
    take_byte   = req_seen && !phase_fail;
    noreq_fail  = in_wreq && !bsy_fail && !item.bus_req &&
                  (poll_cmp > CMP_W'(req_timeout));
    released    = in_wnreq && !item.bus_req;
    ok_end      = released && (left_dec == '0);
    stuck_fail  = in_wnreq && item.bus_req && (poll_cmp > CMP_W'(nreq_timeout));
    finish      = zero_start || bsy_fail || phase_fail || noreq_fail ||
                  ok_end || stuck_fail;
    if (bsy_fail) begin
      end_status = ST_BSY;
    end else if (phase_fail) begin
      end_status = ST_PHASE;
    end else if (noreq_fail) begin
      end_status = ST_NOREQ;
    end else if (stuck_fail) begin
      end_status = ST_STUCK;
    end else begin
      end_status = ST_OK;
    end
  end

  // Next state of the sequencer and its registers.
  always_comb begin
    mode_nxt         = mode_r;
    is_output_nxt    = is_output_r;
    phase_wanted_nxt = phase_wanted_r;
    total_bytes_nxt  = total_bytes_r;
    bytes_left_nxt   = bytes_left_r;
    poll_counter_nxt = poll_counter_r;
    first_poll_nxt   = first_poll_r;
    ack_level_nxt    = ack_level_r;
    drive_level_nxt  = drive_level_r;
    held_byte_nxt    = held_byte_r;
    if (item.func == FUNC_START) begin
      is_output_nxt    = item.direction;
      phase_wanted_nxt = item.expected_phase;
      total_bytes_nxt  = start_count;
      bytes_left_nxt   = start_count;
      poll_counter_nxt = '0;
      first_poll_nxt   = 1'b1;
      ack_level_nxt    = 1'b0;
      held_byte_nxt    = '0;
      drive_level_nxt  = item.direction;
      mode_nxt         = MODE_WREQ;
    end else begin
      case (mode_r)
        MODE_WREQ: begin
          first_poll_nxt = 1'b0;
          if (take_byte) begin
            if (is_output_r) begin
              held_byte_nxt = item.out_byte;
            end
            ack_level_nxt    = 1'b1;
            poll_counter_nxt = '0;
            mode_nxt         = MODE_WNREQ;
          end else if (!bsy_fail && !item.bus_req) begin
            poll_counter_nxt = poll_bumped;
          end
        end
        MODE_WNREQ: begin
          if (released) begin
            ack_level_nxt    = 1'b0;
            bytes_left_nxt   = left_dec;
            poll_counter_nxt = '0;
            first_poll_nxt   = 1'b1;
            mode_nxt         = MODE_WREQ;
          end else begin
            poll_counter_nxt = poll_bumped;
          end
        end
        default: begin
          mode_nxt = MODE_IDLE;
        end
      endcase
    end
    // Any end of the transfer releases ACK and the data bus.
    if (finish) begin
      ack_level_nxt   = 1'b0;
      drive_level_nxt = 1'b0;
      mode_nxt        = MODE_IDLE;
    end
  end

  // Result word for this step.
  always_comb begin
    result                   = '0;
    result.ack_drive         = ack_level_nxt;
    result.data_drive_enable = drive_level_nxt;
    result.data_out          = drive_level_nxt ? held_byte_nxt : 8'd0;
    result.out_byte_taken    = take_byte && is_output_r;
    result.in_byte_valid     = take_byte && !is_output_r;
    result.in_byte           = (take_byte && !is_output_r) ? item.bus_data : 8'd0;
    result.done_res          = finish;
    result.status            = finish ? end_status : ST_OK;
    result.transferred       = finish ? 16'(total_bytes_nxt - bytes_left_nxt) : 16'd0;
  end

  // State registers advance once per processed word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_IDLE;
      is_output_r    <= 1'b0;
      phase_wanted_r <= '0;
      total_bytes_r  <= '0;
      bytes_left_r   <= '0;
      poll_counter_r <= '0;
      first_poll_r   <= 1'b0;
      ack_level_r    <= 1'b0;
      drive_level_r  <= 1'b0;
      held_byte_r    <= '0;
    end else if (step) begin
      mode_r         <= mode_nxt;
      is_output_r    <= is_output_nxt;
      phase_wanted_r <= phase_wanted_nxt;
      total_bytes_r  <= total_bytes_nxt;
      bytes_left_r   <= bytes_left_nxt;
      poll_counter_r <= poll_counter_nxt;
      first_poll_r   <= first_poll_nxt;
      ack_level_r    <= ack_level_nxt;
      drive_level_r  <= drive_level_nxt;
      held_byte_r    <= held_byte_nxt;
    end
  end

endmodule

// ===== rtl/scsi_pio_handshake.sv =====
// An accepted word waits in the input register until its result enters the output register.
// Throughput: one word per cycle while out_tready is high; every input word yields exactly
// one result word. The sequencer step between input and output registers is combinational.
// Reset (rst_n, synchronous, active low) empties both registers, idles the sequencer,
// and sets req_timeout to 50000 and nreq_timeout to 25000 polls.
module scsi_pio_handshake import sph_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata, low bit up: direction, expected_phase[3], byte_count[16], bus_busy,
  // bus_req, bus_phase[3], bus_data[8], out_byte[8], zero fill[7]
  input  logic [47:0] in_tdata,
  // in_tuser: func
  input  logic        in_tuser,
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata, low bit up: ack_drive, data_drive_enable, data_out[8], out_byte_taken,
  // in_byte_valid, in_byte[8], status[3], transferred[16], zero fill[1]
  output logic [39:0] out_tdata,
  // out_tlast: done_res
  output logic        out_tlast,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic        in_valid_r;
  in_item_t    in_item_r;
  logic        out_valid_r;
  out_item_t   out_item_r;
  logic [15:0] req_timeout_r;
  logic [15:0] nreq_timeout_r;
  in_item_t    in_item;
  out_item_t   result;
  logic        step;

  // Unpack the input word.
  always_comb begin
    in_item.func           = in_tuser;
    in_item.direction      = in_tdata[0];
    in_item.expected_phase = in_tdata[3:1];
    in_item.byte_count     = in_tdata[19:4];
    in_item.bus_busy       = in_tdata[20];
    in_item.bus_req        = in_tdata[21];
    in_item.bus_phase      = in_tdata[24:22];
    in_item.bus_data       = in_tdata[32:25];
    in_item.out_byte       = in_tdata[40:33];
  end

  // A word steps through the sequencer when the output register can take its result.
  assign step      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step;
  assign cfg_ready = 1'b1;

  sph_core #(
    .COUNT_BITS (COUNT_BITS),
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .item         (in_item_r),
    .req_timeout  (req_timeout_r),
    .nreq_timeout (nreq_timeout_r),
    .result       (result)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r <= in_item;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item_r <= result;
    end
  end

  // Timeout registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_timeout_r  <= REQ_TIMEOUT_RST;
      nreq_timeout_r <= NREQ_TIMEOUT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_REQ_TIMEOUT:  req_timeout_r  <= cfg_data;
        CFG_NREQ_TIMEOUT: nreq_timeout_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Pack the result word.
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_item_r.done_res;
  assign out_tdata  = {1'b0,
                       out_item_r.transferred,
                       out_item_r.status,
                       out_item_r.in_byte,
                       out_item_r.in_byte_valid,
                       out_item_r.out_byte_taken,
                       out_item_r.data_out,
                       out_item_r.data_drive_enable,
                       out_item_r.ack_drive};

endmodule

// ===== tb/scsi_pio_handshake_tb.sv =====
module scsi_pio_handshake_tb;
  import sph_pkg::*;

  // Kinds of broken byte handshakes mixed into the random transfers.
  localparam int FAULT_BSY     = 0;
  localparam int FAULT_NOREQ   = 1;
  localparam int FAULT_PHASE   = 2;
  localparam int FAULT_STUCK   = 3;
  localparam int FAULT_RESTART = 4;

  localparam int HOLD_OFF_CYCLES = 60;

  // Tracks the initiator sequencer and holds the result words still due.
  class pio_scoreboard;
    logic [15:0] req_limit = REQ_TIMEOUT_RST;
    logic [15:0] nreq_limit = NREQ_TIMEOUT_RST;
    mode_t seq_mode = MODE_IDLE;
    logic is_out = 1'b0;
    logic [2:0] phase_wanted = '0;
    logic [COUNT_BITS_DEF-1:0] total_bytes = '0;
    logic [COUNT_BITS_DEF-1:0] bytes_left = '0;
    logic [TIMER_BITS_DEF-1:0] polls = '0;
    logic first_poll = 1'b0;
    logic ack_level = 1'b0;
    logic drive_level = 1'b0;
    logic [7:0] held_byte = '0;
    out_item_t due_results[$];
    int words_in = 0;
    int words_out = 0;
    int errors = 0;
    int ends_by_status[5];

    function void set_reg(logic idx, logic [15:0] val);
      if (idx == CFG_REQ_TIMEOUT) begin
        req_limit = val;
      end else begin
        nreq_limit = val;
      end
    endfunction

    // Closes the transfer: ACK and the data bus are released.
    function void end_transfer(inout out_item_t r, input status_t st);
      ack_level = 1'b0;
      drive_level = 1'b0;
      seq_mode = MODE_IDLE;
      r.done_res = 1'b1;
      r.status = st;
      r.transferred = 16'(total_bytes - bytes_left);
    endfunction

    // Steps the sequencer by one accepted word and queues the bus levels it yields.
    function void note_word(in_item_t w);
      out_item_t r;
      bit ended;
      r = '0;
      ended = 1'b0;
      words_in++;
      if (w.func == FUNC_START) begin
        is_out = w.direction;
        phase_wanted = w.expected_phase;
        total_bytes = w.byte_count;
        bytes_left = w.byte_count;
        polls = '0;
        first_poll = 1'b1;
        ack_level = 1'b0;
        held_byte = '0;
        drive_level = w.direction;
        seq_mode = MODE_WREQ;
        if (bytes_left == 0) end_transfer(r, ST_OK);
      end else if (seq_mode == MODE_WREQ) begin
        // BSY only matters on the first poll of each byte.
        if (first_poll) begin
          first_poll = 1'b0;
          if (!w.bus_busy) begin
            end_transfer(r, ST_BSY);
            ended = 1'b1;
          end
        end
        if (!ended) begin
          if (w.bus_req) begin
            if (w.bus_phase != phase_wanted) begin
              end_transfer(r, ST_PHASE);
            end else begin
              if (is_out) begin
                held_byte = w.out_byte;
                r.out_byte_taken = 1'b1;
              end else begin
                r.in_byte_valid = 1'b1;
                r.in_byte = w.bus_data;
              end
              ack_level = 1'b1;
              polls = '0;
              seq_mode = MODE_WNREQ;
            end
          end else begin
            if (polls != '1) polls++;
            if (polls > TIMER_BITS_DEF'(req_limit)) end_transfer(r, ST_NOREQ);
          end
        end
      end else if (seq_mode == MODE_WNREQ) begin
        if (!w.bus_req) begin
          ack_level = 1'b0;
          bytes_left = bytes_left - COUNT_BITS_DEF'(1);
          if (bytes_left == 0) begin
            end_transfer(r, ST_OK);
          end else begin
            polls = '0;
            first_poll = 1'b1;
            seq_mode = MODE_WREQ;
          end
        end else begin
          if (polls != '1) polls++;
          if (polls > TIMER_BITS_DEF'(nreq_limit)) end_transfer(r, ST_STUCK);
        end
      end else begin
        seq_mode = MODE_IDLE;
      end
      r.ack_drive = ack_level;
      r.data_drive_enable = drive_level;
      r.data_out = drive_level ? held_byte : 8'h00;
      if (r.done_res) ends_by_status[r.status]++;
      due_results.push_back(r);
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    // Compares one accepted result word with the oldest one due.
    function void check_word(logic [39:0] d, logic last);
      out_item_t e;
      words_out++;
      if (due_results.size() == 0) begin
        $error("result word 0x%0h arrived with nothing due", d);
        errors++;
        return;
      end
      e = due_results.pop_front();
      check_field("ack_drive", 16'(e.ack_drive), 16'(d[0]));
      check_field("data_drive_enable", 16'(e.data_drive_enable), 16'(d[1]));
      check_field("data_out", 16'(e.data_out), 16'(d[9:2]));
      check_field("out_byte_taken", 16'(e.out_byte_taken), 16'(d[10]));
      check_field("in_byte_valid", 16'(e.in_byte_valid), 16'(d[11]));
      check_field("in_byte", 16'(e.in_byte), 16'(d[19:12]));
      check_field("done_res", 16'(e.done_res), 16'(last));
      check_field("status", 16'(e.status), 16'(d[22:20]));
      check_field("transferred", e.transferred, d[38:23]);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;

  bit idle_on = 1'b1;
  bit hold_off_req = 1'b0;
  pio_scoreboard sb = new();

  scsi_pio_handshake DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Upper bound on the whole run.
  initial begin
    #50000000;
    $display("TEST FAILED");
    $finish;
  end

  // Result side: checks accepted words and stalls in bursts or on request.
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
        sb.check_word(out_tdata, out_tlast);
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left = HOLD_OFF_CYCLES;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 6);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic in_item_t rand_word();
    in_item_t w;
    w.func = 1'($urandom_range(0, 1));
    w.direction = 1'($urandom_range(0, 1));
    w.expected_phase = 3'($urandom_range(0, 7));
    w.byte_count = 16'($urandom);
    w.bus_busy = 1'($urandom_range(0, 1));
    w.bus_req = 1'($urandom_range(0, 1));
    w.bus_phase = 3'($urandom_range(0, 7));
    w.bus_data = 8'($urandom);
    w.out_byte = 8'($urandom);
    return w;
  endfunction

  // Offers one word, with an occasional gap before it, and waits for acceptance.
  task automatic send(input in_item_t w);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= w.func;
    in_tdata <= {7'b0, w.out_byte, w.bus_data, w.bus_phase, w.bus_req, w.bus_busy,
                 w.byte_count, w.expected_phase, w.direction};
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_word(w);
  endtask

  task automatic begin_xfer(input bit dir, input logic [2:0] ph, input logic [15:0] cnt);
    in_item_t w;
    w = rand_word();
    w.func = FUNC_START;
    w.direction = dir;
    w.expected_phase = ph;
    w.byte_count = cnt;
    send(w);
  endtask

  task automatic poll_bytes(input bit busy, input bit req, input logic [2:0] ph,
                            input logic [7:0] bdata, input logic [7:0] obyte);
    in_item_t w;
    w = rand_word();
    w.func = FUNC_TICK;
    w.bus_busy = busy;
    w.bus_req = req;
    w.bus_phase = ph;
    w.bus_data = bdata;
    w.out_byte = obyte;
    send(w);
  endtask

  task automatic poll(input bit busy, input bit req, input logic [2:0] ph);
    poll_bytes(busy, req, ph, 8'($urandom), 8'($urandom));
  endtask

  // Stops offering words until every result due has come back.
  task automatic wait_results();
    in_tvalid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes a timeout register once the sequencer is idle and nothing is in flight.
  task automatic write_reg(input logic idx, input logic [15:0] val);
    if (sb.seq_mode != MODE_IDLE) begin
      begin_xfer(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), 16'd0);
    end
    wait_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.set_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  // One transfer as a target would drive it, with a chance of a broken byte.
  task automatic run_transfer(input bit dir, input logic [2:0] ph, input int unsigned nbytes);
    int unsigned waits;
    int unsigned holds;
    int fault;
    begin_xfer(dir, ph, 16'(nbytes));
    for (int unsigned b = 0; b < nbytes; b++) begin
      fault = $urandom_range(0, 29);
      waits = $urandom_range(0, sb.req_limit < 4 ? sb.req_limit : 4);
      holds = $urandom_range(0, sb.nreq_limit < 4 ? sb.nreq_limit : 4);
      if (fault == FAULT_BSY) begin
        poll(1'b0, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
        return;
      end
      if (fault == FAULT_NOREQ && sb.req_limit <= 16) waits = sb.req_limit + 1;
      for (int unsigned i = 0; i < waits; i++) begin
        poll(i == 0 ? 1'b1 : 1'($urandom_range(0, 1)), 1'b0, 3'($urandom_range(0, 7)));
      end
      if (waits > sb.req_limit) return;
      if (fault == FAULT_PHASE) begin
        poll(waits == 0 ? 1'b1 : 1'($urandom_range(0, 1)), 1'b1,
             ph ^ 3'($urandom_range(1, 7)));
        return;
      end
      poll(waits == 0 ? 1'b1 : 1'($urandom_range(0, 1)), 1'b1, ph);
      if (fault == FAULT_STUCK && sb.nreq_limit <= 16) holds = sb.nreq_limit + 1;
      for (int unsigned i = 0; i < holds; i++) begin
        poll(1'($urandom_range(0, 1)), 1'b1, 3'($urandom_range(0, 7)));
      end
      if (holds > sb.nreq_limit) return;
      // Leave ACK raised; the next start drops this transfer.
      if (fault == FAULT_RESTART) return;
      poll(1'($urandom_range(0, 1)), 1'b0, 3'($urandom_range(0, 7)));
    end
  endtask

  // Stimulus.
  initial begin
    in_item_t w;
    int target;
    bit paused;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser <= 1'b0;
    in_tdata <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= 1'b0;
    cfg_data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Ticks while idle, with every field at both extremes.
    w = '1;
    w.func = FUNC_TICK;
    send(w);
    w = '0;
    send(w);
    // A zero count ends at once.
    begin_xfer(1'b1, 3'd7, 16'd0);
    // One out byte and two in bytes with extreme data.
    begin_xfer(1'b1, 3'd7, 16'd1);
    poll_bytes(1'b1, 1'b1, 3'd7, 8'h00, 8'hFF);
    poll(1'b0, 1'b0, 3'd0);
    begin_xfer(1'b0, 3'd0, 16'd2);
    poll_bytes(1'b1, 1'b1, 3'd0, 8'hFF, 8'h00);
    poll(1'b1, 1'b0, 3'd7);
    poll_bytes(1'b1, 1'b1, 3'd0, 8'h00, 8'hFF);
    poll(1'b1, 1'b0, 3'd0);
    // BSY dropped on the first poll of the largest transfer.
    begin_xfer(1'b1, 3'd3, 16'hFFFF);
    poll(1'b0, 1'b1, 3'd3);
    // Phase change on the REQ poll.
    begin_xfer(1'b0, 3'd5, 16'd3);
    poll(1'b1, 1'b1, 3'd2);
    // A new start while ACK is high abandons the running transfer.
    begin_xfer(1'b1, 3'd1, 16'd4);
    poll(1'b1, 1'b1, 3'd1);
    begin_xfer(1'b0, 3'd6, 16'd1);
    poll(1'b1, 1'b1, 3'd6);
    poll(1'b1, 1'b0, 3'd6);

    // Reset timeouts are long: many missed polls end neither wait.
    begin_xfer(1'b0, 3'd2, 16'd1);
    for (int unsigned i = 0; i < 40; i++) begin
      poll(i == 0 ? 1'b1 : 1'($urandom_range(0, 1)), 1'b0, 3'($urandom_range(0, 7)));
    end
    poll(1'($urandom_range(0, 1)), 1'b1, 3'd2);
    for (int unsigned i = 0; i < 40; i++) begin
      poll(1'($urandom_range(0, 1)), 1'b1, 3'($urandom_range(0, 7)));
    end
    poll(1'($urandom_range(0, 1)), 1'b0, 3'($urandom_range(0, 7)));

    // Zero timeouts: one missed poll ends either wait.
    write_reg(CFG_REQ_TIMEOUT, 16'd0);
    write_reg(CFG_NREQ_TIMEOUT, 16'd0);
    begin_xfer(1'b0, 3'd4, 16'd2);
    poll(1'b1, 1'b0, 3'd4);
    begin_xfer(1'b1, 3'd2, 16'd1);
    poll(1'b1, 1'b1, 3'd2);
    poll(1'b1, 1'b1, 3'd2);

    // Random transfers over several timeout settings.
    for (int p = 0; p < 6; p++) begin
      if (p == 5) idle_on = 1'b0;
      if (p == 0) begin
        write_reg(CFG_REQ_TIMEOUT, 16'hFFFF);
        write_reg(CFG_NREQ_TIMEOUT, 16'hFFFF);
      end else begin
        write_reg(CFG_REQ_TIMEOUT, 16'($urandom_range(0, 8)));
        write_reg(CFG_NREQ_TIMEOUT, 16'($urandom_range(0, 8)));
      end
      // The result side holds off long enough to back up the input.
      if (p == 1) hold_off_req = 1'b1;
      paused = 1'b0;
      target = sb.words_in + 200;
      while (sb.words_in < target) begin
        if (p == 3 && !paused && sb.words_in > target - 100) begin
          wait_results();
          paused = 1'b1;
        end
        if ($urandom_range(0, 7) == 0) begin
          repeat ($urandom_range(1, 4)) send(rand_word());
        end else begin
          run_transfer(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                       $urandom_range(0, 15) == 0 ? 0 :
                       $urandom_range(0, 19) == 0 ? $urandom_range(10, 30) :
                       $urandom_range(1, 6));
        end
      end
    end

    wait_results();
    repeat (10) @(posedge clk);
    $display("Run covered %0d input words and %0d result words over several timeout settings.",
             sb.words_in, sb.words_out);
    $display("Transfer endings: %0d ok, %0d lost BSY, %0d no REQ, %0d phase change, %0d stuck REQ.",
             sb.ends_by_status[ST_OK], sb.ends_by_status[ST_BSY], sb.ends_by_status[ST_NOREQ],
             sb.ends_by_status[ST_PHASE], sb.ends_by_status[ST_STUCK]);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
